/* hdl/poq_pkg.sv */
package poq_pkg;

  localparam int DEPTH     = 16;
  localparam int PAGE_BITS = 16;

  // Field widths on the stream ports.
  localparam int ACT_W    = 3;
  localparam int PAGE_W   = 16;
  localparam int STAT_W   = 2;
  localparam int COUNT_W  = 5;
  localparam int OUT_W    = PAGE_W + STAT_W + COUNT_W + 1;
  localparam int OUT_BYTES_W = ((OUT_W + 7) / 8) * 8;
  localparam int IN_BYTES_W  = ((PAGE_W + 7) / 8) * 8;

  // Internal widths follow the list depth.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [DEPTH-1:0]     slot_mask_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_APPEND  = 3'd0,
    ACT_POP_OLD = 3'd1,
    ACT_POP_NEW = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_LOOKUP  = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_NOTFOUND = 2'd2,
    STAT_FULL     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic compare;
    logic apply;
  } ctl_cmd_t;

endpackage

/* hdl/page_order_queue_core.sv */
// A transaction passes the capture, compare and apply steps, and its result register then feeds the master side.
// Each transaction runs the controller's three-step sequence (capture, parallel compare, apply);
// a stalled result register holds off the apply step, and new input is accepted only after apply.
// The next input transaction is accepted while a finished result still waits to be taken.
// Reset (rst, synchronous, active high) empties the list and drops any pending result;
// slot contents are not cleared and are never observed before being written.
module page_order_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] page
  input  logic [2:0]  s_axis_tuser,   // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata    // [15:0] result_page, [17:16] status,
                                      // [22:18] entry_count, [23] is_empty
);
  import poq_pkg::*;

  ctl_cmd_t           cmd;
  logic [PAGE_W-1:0]  res_page;
  logic [STAT_W-1:0]  res_status;
  logic [COUNT_W-1:0] res_count;
  logic               res_empty;

  // The controller sequences each transaction; it never looks at the payload.
  poq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .cmd       (cmd)
  );

  // The datapath holds the ordered slot row, the entry count and the result register.
  poq_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_action  (s_axis_tuser),
    .in_page    (s_axis_tdata[PAGE_W-1:0]),
    .res_page   (res_page),
    .res_status (res_status),
    .res_count  (res_count),
    .res_empty  (res_empty)
  );

  // Result fields packed from the lowest bit up.
  assign m_axis_tdata = {res_empty, res_count, res_status, res_page};

endmodule

/* hdl/poq_ctrl.sv */
module poq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output poq_pkg::ctl_cmd_t cmd
);
  import poq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = S_APPLY;
      end
      S_APPLY: begin
        // The result register must be free or emptying this cycle.
        if (!out_valid || out_ready) begin
          cmd.apply      = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_apply_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.apply |=> out_valid)
    else $error("result not marked valid after apply");

  a_capture_to_cmp: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_CMP))
    else $error("compare step skipped after capture");

  a_valid_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_APPLY))
    else $error("result appeared without an apply step");

endmodule

/* hdl/poq_datapath.sv */
module poq_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  poq_pkg::ctl_cmd_t            cmd,
  input  logic [poq_pkg::ACT_W-1:0]    in_action,
  input  logic [poq_pkg::PAGE_W-1:0]   in_page,
  output logic [poq_pkg::PAGE_W-1:0]   res_page,
  output logic [poq_pkg::STAT_W-1:0]   res_status,
  output logic [poq_pkg::COUNT_W-1:0]  res_count,
  output logic                         res_empty
);
  import poq_pkg::*;

  page_t      slots [DEPTH];
  cnt_t       count;
  logic [ACT_W-1:0] act;
  page_t      pg;
  slot_mask_t match;

  cnt_t       cnt_dec;
  idx_t       last_idx;
  logic       nonempty;
  logic       full;
  logic       any_match;
  slot_mask_t first_hot;
  slot_mask_t del_hot;
  slot_mask_t shift_mask;
  logic       do_del;
  logic       do_app;
  page_t      page_sel;
  status_t    stat_sel;
  cnt_t       count_next;

  // Capture the item and compare it against every held slot.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= in_action;
      pg  <= in_page[PAGE_BITS-1:0];
    end
    if (cmd.compare) begin
      for (int i = 0; i < DEPTH; i++) begin
        match[i] <= (slots[i] == pg) && (cnt_t'(i) < count);
      end
    end
  end

  always_comb begin
    cnt_dec    = count - cnt_t'(1);
    last_idx   = cnt_dec[IDX_W-1:0];
    nonempty   = (count != '0);
    full       = (count >= cnt_t'(DEPTH));
    any_match  = |match;
    first_hot  = match & (~match + slot_mask_t'(1));
    del_hot    = slot_mask_t'(1);
    do_del     = 1'b0;
    do_app     = 1'b0;
    page_sel   = '0;
    stat_sel   = STAT_OK;
    unique case (act)
      ACT_APPEND: begin
        if (full) stat_sel = STAT_FULL;
        else      do_app   = 1'b1;
      end
      ACT_POP_OLD: begin
        if (!nonempty) begin
          stat_sel = STAT_EMPTY;
        end else begin
          do_del   = 1'b1;
          page_sel = slots[0];
        end
      end
      ACT_POP_NEW: begin
        if (!nonempty) begin
          stat_sel = STAT_EMPTY;
        end else begin
          do_del   = 1'b1;
          del_hot  = slot_mask_t'(1) << last_idx;
          page_sel = slots[last_idx];
        end
      end
      ACT_REMOVE: begin
        if (!any_match) begin
          stat_sel = STAT_NOTFOUND;
        end else begin
          do_del   = 1'b1;
          page_sel = pg;
          // Oldest wins, then newest, then the oldest interior copy.
          if (match[0])             del_hot = slot_mask_t'(1);
          else if (match[last_idx]) del_hot = slot_mask_t'(1) << last_idx;
          else                      del_hot = first_hot;
        end
      end
      ACT_LOOKUP: begin
        stat_sel = any_match ? STAT_OK : STAT_NOTFOUND;
      end
      default: ;
    endcase
    shift_mask = ~(del_hot - slot_mask_t'(1));
    count_next = count;
    if (do_app)      count_next = count + cnt_t'(1);
    else if (do_del) count_next = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // Slot row: deletion shifts newer entries toward slot 0, append writes at count.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (do_del && shift_mask[i] && (i < DEPTH - 1)) begin
          slots[i] <= slots[(i < DEPTH - 1) ? i + 1 : i];
        end else if (do_app && (count == cnt_t'(i))) begin
          slots[i] <= pg;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      res_page   <= PAGE_W'(page_sel);
      res_status <= stat_sel;
      res_count  <= COUNT_W'(count_next);
      res_empty  <= (count_next == '0);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(DEPTH))
    else $error("entry count beyond depth");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !cmd.apply |=> $stable(count))
    else $error("entry count changed outside apply");

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import poq_pkg::*;

  // Actions five to seven are not decoded by the block and leave the list untouched.
  localparam logic [ACT_W-1:0] ACT_RESERVED_FIRST = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RESERVED_LAST  = 3'd7;

  localparam int RANDOM_OPS = 500;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } op_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;    // [15:0] page
  logic [2:0]  s_axis_tuser = '0;    // [2:0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // [15:0] result_page, [17:16] status,
                                     // [22:18] entry_count, [23] is_empty

  // Predicted list contents, oldest entry at index 0.
  page_t      resident_pages[$];
  op_result_t pending_results[$];

  int send_gap_pct   = 9;
  int recv_stall_pct = 79;
  int fail_count     = 0;
  bit grow_list      = 1'b1;

  page_order_queue_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Applies one action to the predicted list and returns the result it should produce.
  function automatic op_result_t apply_page_action(input logic [ACT_W-1:0] act,
                                                   input page_t pg);
    op_result_t res;
    int n;
    int hit;
    int i;
    n = resident_pages.size();
    hit = -1;
    res.page = '0;
    res.status = STAT_OK;
    case (act)
      ACT_APPEND: begin
        if (n >= DEPTH) res.status = STAT_FULL;
        else resident_pages.push_back(pg);
      end
      ACT_POP_OLD: begin
        if (n == 0) res.status = STAT_EMPTY;
        else res.page = resident_pages.pop_front();
      end
      ACT_POP_NEW: begin
        if (n == 0) res.status = STAT_EMPTY;
        else res.page = resident_pages.pop_back();
      end
      ACT_REMOVE: begin
        // The two end entries win over interior copies; among those the oldest wins.
        if (n == 0) begin
          hit = -1;
        end else if (resident_pages[0] == pg) begin
          hit = 0;
        end else if (resident_pages[n-1] == pg) begin
          hit = n - 1;
        end else begin
          for (i = 1; i < n - 1; i++) begin
            if (hit < 0 && resident_pages[i] == pg) hit = i;
          end
        end
        if (hit < 0) begin
          res.status = STAT_NOTFOUND;
        end else begin
          res.page = resident_pages[hit];
          resident_pages.delete(hit);
        end
      end
      ACT_LOOKUP: begin
        res.status = STAT_NOTFOUND;
        foreach (resident_pages[j]) begin
          if (resident_pages[j] == pg) res.status = STAT_OK;
        end
      end
      default: begin
      end
    endcase
    res.count = COUNT_W'(resident_pages.size());
    res.empty = (resident_pages.size() == 0);
    return res;
  endfunction

  // Sends one transaction, with random idle cycles ahead of it, and records its prediction.
  task automatic issue_page_op(input logic [ACT_W-1:0] act, input page_t pg);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= pg;
    do @(posedge clk); while (!s_axis_tready);
    pending_results.push_back(apply_page_action(act, pg));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_list();
    issue_page_op(ACT_POP_OLD, 16'h0000);
    issue_page_op(ACT_POP_NEW, 16'hFFFF);
    issue_page_op(ACT_REMOVE, 16'h0000);
    issue_page_op(ACT_LOOKUP, 16'hFFFF);
  endtask

  // Duplicates are placed so that the removal test can tell which copy goes.
  task automatic test_fill_to_full();
    page_t fill_pages [DEPTH] = '{16'h1111, 16'h0000, 16'h2222, 16'hFFFF,
                                  16'h1111, 16'h2222, 16'h5A5A, 16'hA5A5,
                                  16'h2222, 16'h0001, 16'h8000, 16'h7FFF,
                                  16'hFFFE, 16'h3333, 16'h4444, 16'hFFFF};
    foreach (fill_pages[k]) issue_page_op(ACT_APPEND, fill_pages[k]);
    issue_page_op(ACT_APPEND, 16'h9999);
  endtask

  task automatic test_remove_choice();
    issue_page_op(ACT_REMOVE, 16'h1111);  // oldest entry and an interior copy
    issue_page_op(ACT_REMOVE, 16'hFFFF);  // newest entry and an interior copy
    issue_page_op(ACT_REMOVE, 16'h2222);  // interior copies only
    issue_page_op(ACT_REMOVE, 16'h1234);
    issue_page_op(ACT_LOOKUP, 16'h5A5A);
  endtask

  task automatic test_reserved_actions();
    issue_page_op(ACT_RESERVED_LAST, 16'hFFFF);
    wait_for_results();
  endtask

  // Random traffic that alternates between growing the list to full and draining it.
  // Pages are mostly drawn from the list itself or a small pool so that removes and
  // lookups hit, with duplicates and with copies at both ends and in the middle.
  task automatic test_random_traffic(input int gap_pct, input int stall_pct);
    logic [ACT_W-1:0] act;
    page_t pg;
    page_t mask;
    int roll;
    int k;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    for (k = 0; k < RANDOM_OPS; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        act = ACT_W'($urandom_range(ACT_RESERVED_FIRST, ACT_RESERVED_LAST));
      end else if (grow_list) begin
        if (roll < 55) act = ACT_APPEND;
        else if (roll < 65) act = ACT_POP_OLD;
        else if (roll < 75) act = ACT_POP_NEW;
        else if (roll < 90) act = ACT_REMOVE;
        else act = ACT_LOOKUP;
      end else begin
        if (roll < 15) act = ACT_APPEND;
        else if (roll < 35) act = ACT_POP_OLD;
        else if (roll < 55) act = ACT_POP_NEW;
        else if (roll < 85) act = ACT_REMOVE;
        else act = ACT_LOOKUP;
      end

      roll = $urandom_range(0, 9);
      if (roll < 5 && resident_pages.size() != 0) begin
        pg = resident_pages[$urandom_range(0, resident_pages.size() - 1)];
      end else if (roll < 8) begin
        mask = '0;
        if ($urandom_range(0, 1)) mask = '1;
        pg = page_t'($urandom_range(0, 7)) ^ mask;
      end else begin
        pg = page_t'($urandom);
      end

      // Halfway through, hold the sender back until the block has answered everything.
      if (k == RANDOM_OPS / 2) wait_for_results();
      issue_page_op(act, pg);

      if (resident_pages.size() == DEPTH && $urandom_range(0, 3) == 0) grow_list = 1'b0;
      else if (resident_pages.size() == 0 && $urandom_range(0, 3) == 0) grow_list = 1'b1;
      else if ($urandom_range(0, 49) == 0) grow_list = !grow_list;
    end
  endtask

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.page   = m_axis_tdata[15:0];
      got.status = status_t'(m_axis_tdata[17:16]);
      got.count  = m_axis_tdata[22:18];
      got.empty  = m_axis_tdata[23];
      if (pending_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("%0t: result transaction with nothing pending, data %h",
                   $time, m_axis_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got.page !== want.page || got.status !== want.status ||
            got.count !== want.count || got.empty !== want.empty) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: expected page %h status %0d count %0d empty %0b, got page %h status %0d count %0d empty %0b",
                     $time, want.page, want.status, want.count, want.empty,
                     got.page, got.status, got.count, got.empty);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_fill_to_full();
    test_remove_choice();
    test_reserved_actions();
    test_random_traffic(9, 79);
    test_random_traffic(79, 9);
    test_random_traffic(0, 0);
    wait_for_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/poq_pkg.sv
hdl/poq_ctrl.sv
hdl/poq_datapath.sv
hdl/page_order_queue_core.sv
test/tb_top.sv
